/* hdl/ntcbt_pkg.sv */
package ntcbt_pkg;

   // Configuration register map
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FIXED_RES    = 3'd0,
      REG_NOMINAL_RES  = 3'd1,
      REG_NOMINAL_TEMP = 3'd2,
      REG_BETA         = 3'd3,
      REG_OFFSET       = 3'd4,
      REG_FAHRENHEIT   = 3'd5,
      REG_RAW_MIN      = 3'd6,
      REG_RAW_MAX      = 3'd7
   } csr_reg_type;

   // Register reset values
   localparam logic [19:0]        RST_FIXED_RES    = 20'd10000;
   localparam logic [19:0]        RST_NOMINAL_RES  = 20'd10000;
   localparam logic [15:0]        RST_NOMINAL_TEMP = 16'd29815;
   localparam logic [13:0]        RST_BETA         = 14'd3950;
   localparam logic signed [14:0] RST_OFFSET       = 15'sd0;
   localparam logic [11:0]        RST_RAW_MIN      = 12'd13;
   localparam logic [11:0]        RST_RAW_MAX      = 12'd4082;

   // Log2 unit: Q1.30 mantissa, 24 fraction bits
   localparam int MANT_W    = 31;
   localparam int FRAC_BITS = 24;
   localparam int RATIO_W   = 32;

   // round(ln2 * 2^30)
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   // 100 * 2^40, numerator of the reciprocal temperature
   localparam int          INV_W   = 47;
   localparam logic [46:0] INV_NUM = 47'd109951162777600;

   // Output conversion
   localparam logic [16:0]        TCK_CLAMP     = 17'd131071;
   localparam logic signed [18:0] KELVIN_0C     = 19'sd27315;
   localparam logic signed [18:0] C_LOW         = -19'sd20000;
   localparam logic signed [18:0] C_HIGH        = 19'sd50000;
   localparam logic [19:0]        RECIP5        = 20'd838861;
   localparam int                 RECIP5_SHIFT  = 22;
   localparam logic signed [17:0] F_OFFSET      = 18'sd3200;
   localparam logic signed [16:0] TEMP_MIN      = -17'sd10000;
   localparam logic signed [16:0] TEMP_MAX      = 17'sd50000;

endpackage

/* hdl/ntc_beta_temperature_convert_core.sv */
// Throughput: one sample per cycle unless a held result stalls; the four pipelined dividers (32, 47,
// 47 and 48 bit quotients, one bit per stage) and the 24 squaring stages of the log2 unit set the depth.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits and loads the register defaults.
module ntc_beta_temperature_convert_core #(
   parameter int ADC_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ntcbt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ntcbt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ADC_BITS-1:0]               req_adc_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [16:0]                rsp_temperature_centi,
   output logic                              rsp_reading_valid
);
   import ntcbt_pkg::*;

   localparam int RAW_W = ADC_BITS;
   localparam int CMP_W = (ADC_BITS > 12) ? ADC_BITS : 12;
   localparam int N1_W  = RAW_W + 36;
   localparam int D1_W  = RAW_W + 20;
   localparam logic [RAW_W-1:0] FS = '1;

   // Configuration registers
   logic [19:0]        rfix_ff, r0_ff;
   logic [15:0]        t0_ff;
   logic [13:0]        beta_ff;
   logic signed [14:0] off_ff;
   logic               fmode_ff;
   logic [11:0]        rmin_ff, rmax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rfix_ff  <= RST_FIXED_RES;
         r0_ff    <= RST_NOMINAL_RES;
         t0_ff    <= RST_NOMINAL_TEMP;
         beta_ff  <= RST_BETA;
         off_ff   <= RST_OFFSET;
         fmode_ff <= 1'b0;
         rmin_ff  <= RST_RAW_MIN;
         rmax_ff  <= RST_RAW_MAX;
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_FIXED_RES:    rfix_ff  <= csr_wdata;
            REG_NOMINAL_RES:  r0_ff    <= csr_wdata;
            REG_NOMINAL_TEMP: t0_ff    <= csr_wdata[15:0];
            REG_BETA:         beta_ff  <= csr_wdata[13:0];
            REG_OFFSET:       off_ff   <= $signed(csr_wdata[14:0]);
            REG_FAHRENHEIT:   fmode_ff <= csr_wdata[0];
            REG_RAW_MIN:      rmin_ff  <= csr_wdata[11:0];
            REG_RAW_MAX:      rmax_ff  <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // zero in a scale register acts as one
   logic [19:0] rfix_eff, r0_eff;
   logic [15:0] t0_eff;
   logic [13:0] beta_eff;

   assign rfix_eff = (rfix_ff == '0) ? 20'd1 : rfix_ff;
   assign r0_eff   = (r0_ff == '0) ? 20'd1 : r0_ff;
   assign t0_eff   = (t0_ff == '0) ? 16'd1 : t0_ff;
   assign beta_eff = (beta_ff == '0) ? 14'd1 : beta_ff;

   // Global advance: the pipeline moves unless a finished result is held
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Stage A: input register
   logic             a_valid_ff;
   logic [RAW_W-1:0] a_raw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
      end
      if (adv) begin
         a_raw_ff <= req_adc_sample;
      end
   end

   // Stage B: window check, divider operands
   logic             b_valid_ff, b_ok_ff;
   logic [N1_W-1:0]  b_num_ff;
   logic [D1_W-1:0]  b_den_ff;
   logic             b_ok_in;
   logic [D1_W-1:0]  b_prod_in;
   logic [D1_W-1:0]  b_den_in;
   logic [RAW_W-1:0] b_diff;

   assign b_ok_in = (CMP_W'(a_raw_ff) >= CMP_W'(rmin_ff)) &&
                    (CMP_W'(a_raw_ff) <= CMP_W'(rmax_ff)) &&
                    (a_raw_ff != '0) && (a_raw_ff != FS);
   assign b_diff    = FS - a_raw_ff;
   assign b_prod_in = D1_W'(rfix_eff) * D1_W'(a_raw_ff);
   assign b_den_in  = D1_W'(b_diff) * D1_W'(r0_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
      if (adv) begin
         b_ok_ff  <= b_ok_in;
         b_num_ff <= {b_prod_in, 16'd0};
         b_den_ff <= b_den_in;
      end
   end

   // Ratio R/R0 in Q16.16
   logic               d1_valid, d1_sat, d1_ok;
   logic [RATIO_W-1:0] d1_quo;

   ntcbt_div #(
      .N_W (N1_W),
      .D_W (D1_W),
      .Q_W (RATIO_W),
      .S_W (1)
   ) u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (b_valid_ff),
      .in_num    (b_num_ff),
      .in_den    (b_den_ff),
      .in_side   (b_ok_ff),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_sat   (d1_sat),
      .out_side  (d1_ok)
   );

   // Stage C: clamp ratio to [1, 2^32-1]
   logic               c_valid_ff, c_ok_ff;
   logic [RATIO_W-1:0] c_ratio_ff;
   logic [RATIO_W-1:0] c_ratio_in;

   always_comb begin
      c_ratio_in = d1_sat ? '1 : d1_quo;
      if (c_ratio_in == '0) begin
         c_ratio_in = RATIO_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= d1_valid;
      end
      if (adv) begin
         c_ok_ff    <= d1_ok;
         c_ratio_ff <= c_ratio_in;
      end
   end

   // Stage D: leading one position
   logic               d_valid_ff, d_ok_ff;
   logic [RATIO_W-1:0] d_ratio_ff;
   logic [4:0]         d_e_ff;
   logic [4:0]         d_e_in;

   always_comb begin
      d_e_in = '0;
      for (int i = 0; i < RATIO_W; i++) begin
         if (c_ratio_ff[i]) begin
            d_e_in = 5'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= c_valid_ff;
      end
      if (adv) begin
         d_ok_ff    <= c_ok_ff;
         d_ratio_ff <= c_ratio_ff;
         d_e_ff     <= d_e_in;
      end
   end

   // Stage E and squaring stages: mantissa in Q1.30, one fraction bit per stage
   logic [MANT_W-1:0]    sq_m_ff    [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] sq_frac_ff [0:FRAC_BITS];
   logic [4:0]           sq_e_ff    [0:FRAC_BITS];
   logic                 sq_ok_ff   [0:FRAC_BITS];
   logic                 sq_valid_ff[0:FRAC_BITS];
   logic [61:0]          e_wide;

   assign e_wide = {d_ratio_ff, 30'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_valid_ff[0] <= d_valid_ff;
      end
      if (adv) begin
         sq_m_ff[0]    <= MANT_W'(e_wide >> d_e_ff);
         sq_frac_ff[0] <= '0;
         sq_e_ff[0]    <= d_e_ff;
         sq_ok_ff[0]   <= d_ok_ff;
      end
   end

   for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_sq
      logic [2*MANT_W-1:0] prod;
      logic [31:0]         sq;

      assign prod = (2*MANT_W)'(sq_m_ff[k-1]) * (2*MANT_W)'(sq_m_ff[k-1]);
      assign sq   = 32'(prod >> 30);

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[k] <= sq_valid_ff[k-1];
         end
         if (adv) begin
            sq_m_ff[k]    <= sq[31] ? sq[31:1] : sq[30:0];
            sq_frac_ff[k] <= {sq_frac_ff[k-1][FRAC_BITS-2:0], sq[31]};
            sq_e_ff[k]    <= sq_e_ff[k-1];
            sq_ok_ff[k]   <= sq_ok_ff[k-1];
         end
      end
   end

   // Stage F: signed log2 in Q.24, split into sign and magnitude
   logic               f_valid_ff, f_ok_ff, f_neg_ff;
   logic [28:0]        f_abs_ff;
   logic signed [5:0]  f_exp;
   logic signed [29:0] f_l2;

   assign f_exp = $signed({1'b0, sq_e_ff[FRAC_BITS]}) - 6'sd16;
   assign f_l2  = ($signed(30'(f_exp)) <<< FRAC_BITS) +
                  $signed(30'({1'b0, sq_frac_ff[FRAC_BITS]}));

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= sq_valid_ff[FRAC_BITS];
      end
      if (adv) begin
         f_ok_ff  <= sq_ok_ff[FRAC_BITS];
         f_neg_ff <= f_l2[29];
         f_abs_ff <= 29'(f_l2[29] ? -f_l2 : f_l2);
      end
   end

   // Stage G: natural log magnitude, rounded
   logic        g_valid_ff, g_ok_ff, g_neg_ff;
   logic [27:0] g_ln_ff;
   logic [58:0] g_prod;

   assign g_prod = 59'(f_abs_ff) * 59'(LN2_Q30) + (59'(1) << 29);

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (adv) begin
         g_valid_ff <= f_valid_ff;
      end
      if (adv) begin
         g_ok_ff  <= f_ok_ff;
         g_neg_ff <= f_neg_ff;
         g_ln_ff  <= 28'(g_prod >> 30);
      end
   end

   // 1/T0 and ln/B side by side, same depth
   logic             inv0_valid, inv0_sat, inv0_ok;
   logic             term_valid, term_sat, term_neg;
   logic [INV_W-1:0] inv0_quo, term_quo;

   ntcbt_div #(
      .N_W (INV_W),
      .D_W (16),
      .Q_W (INV_W),
      .S_W (1)
   ) u_inv0_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (g_valid_ff),
      .in_num    (INV_NUM),
      .in_den    (t0_eff),
      .in_side   (g_ok_ff),
      .out_valid (inv0_valid),
      .out_quo   (inv0_quo),
      .out_sat   (inv0_sat),
      .out_side  (inv0_ok)
   );

   ntcbt_div #(
      .N_W (INV_W),
      .D_W (14),
      .Q_W (INV_W),
      .S_W (1)
   ) u_term_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (g_valid_ff),
      .in_num    (INV_W'({g_ln_ff, 16'd0})),
      .in_den    (beta_eff),
      .in_side   (g_neg_ff),
      .out_valid (term_valid),
      .out_quo   (term_quo),
      .out_sat   (term_sat),
      .out_side  (term_neg)
   );

   // Stage H: 1/T and rounded reciprocal operands
   logic               h_valid_ff, h_ok_ff, h_nonpos_ff;
   logic [47:0]        h_num_ff, h_den_ff;
   logic signed [48:0] h_inv;

   assign h_inv = term_neg ? ($signed({2'b00, inv0_quo}) - $signed({2'b00, term_quo}))
                           : ($signed({2'b00, inv0_quo}) + $signed({2'b00, term_quo}));

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (adv) begin
         h_valid_ff <= inv0_valid;
      end
      if (adv) begin
         h_ok_ff     <= inv0_ok;
         h_nonpos_ff <= (h_inv <= 49'sd0);
         h_num_ff    <= 48'(INV_NUM) + 48'(h_inv[47:1]);
         h_den_ff    <= h_inv[47:0];
      end
   end

   // T in centikelvin
   logic        d3_valid, d3_sat, d3_ok, d3_nonpos;
   logic [47:0] d3_quo;

   ntcbt_div #(
      .N_W (48),
      .D_W (48),
      .Q_W (48),
      .S_W (2)
   ) u_temp_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (h_valid_ff),
      .in_num    (h_num_ff),
      .in_den    (h_den_ff),
      .in_side   ({h_ok_ff, h_nonpos_ff}),
      .out_valid (d3_valid),
      .out_quo   (d3_quo),
      .out_sat   (d3_sat),
      .out_side  ({d3_ok, d3_nonpos})
   );

   // Stage I: Celsius with offset, clamped to a range that keeps the final saturation
   logic               i_valid_ff, i_ok_ff, i_hi_ff;
   logic signed [16:0] i_c_ff;
   logic [16:0]        i_tck;
   logic signed [18:0] i_c;
   logic signed [18:0] i_c_clamp;

   assign i_tck = (d3_quo > 48'(TCK_CLAMP)) ? TCK_CLAMP : d3_quo[16:0];
   assign i_c   = $signed({2'b00, i_tck}) - KELVIN_0C + 19'(off_ff);

   always_comb begin
      i_c_clamp = i_c;
      if (i_c < C_LOW) begin
         i_c_clamp = C_LOW;
      end else if (i_c > C_HIGH) begin
         i_c_clamp = C_HIGH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
      end else if (adv) begin
         i_valid_ff <= d3_valid;
      end
      if (adv) begin
         i_ok_ff <= d3_ok;
         i_hi_ff <= d3_nonpos;
         i_c_ff  <= 17'(i_c_clamp);
      end
   end

   // Stage J: 9*C/5 by reciprocal multiply, magnitude rounded half away from zero
   logic               j_valid_ff, j_ok_ff, j_hi_ff, j_neg_ff;
   logic signed [16:0] j_c_ff;
   logic [38:0]        j_prod_ff;
   logic signed [19:0] j_n;
   logic [18:0]        j_mag;

   assign j_n   = 20'(i_c_ff) * 20'sd9;
   assign j_mag = 19'(j_n[19] ? -j_n : j_n) + 19'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         j_valid_ff <= 1'b0;
      end else if (adv) begin
         j_valid_ff <= i_valid_ff;
      end
      if (adv) begin
         j_ok_ff   <= i_ok_ff;
         j_hi_ff   <= i_hi_ff;
         j_neg_ff  <= j_n[19];
         j_c_ff    <= i_c_ff;
         j_prod_ff <= 39'(j_mag) * 39'(RECIP5);
      end
   end

   // Stage K: unit select, saturation, result register
   logic [16:0]        k_r;
   logic signed [17:0] k_f, k_sel, k_sat;
   logic signed [16:0] temp_ff;
   logic               ok_ff;

   assign k_r   = 17'(j_prod_ff >> RECIP5_SHIFT);
   assign k_f   = (j_neg_ff ? -$signed({1'b0, k_r}) : $signed({1'b0, k_r})) + F_OFFSET;
   assign k_sel = fmode_ff ? k_f : 18'(j_c_ff);

   always_comb begin
      k_sat = k_sel;
      if (j_hi_ff || (k_sel > 18'(TEMP_MAX))) begin
         k_sat = 18'(TEMP_MAX);
      end else if (k_sel < 18'(TEMP_MIN)) begin
         k_sat = 18'(TEMP_MIN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= j_valid_ff;
      end
      if (adv) begin
         ok_ff   <= j_ok_ff;
         temp_ff <= j_ok_ff ? 17'(k_sat) : '0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = temp_ff;
   assign rsp_reading_valid     = ok_ff;

   // the two parallel dividers stay in lockstep
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      inv0_valid == term_valid)
      else $error("reciprocal dividers out of step");

   // operands are sized so these dividers never overflow while 1/T is positive
   a_div_no_sat: assert property (@(posedge clock) disable iff (reset)
      !((inv0_valid && inv0_sat) || (term_valid && term_sat) ||
        (d3_valid && !d3_nonpos && d3_sat)))
      else $error("divider quotient overflow");

   // an out-of-window sample reports zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reading_valid) |-> (rsp_temperature_centi == 17'sd0))
      else $error("invalid reading with nonzero temperature");

   // results are saturated
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_temperature_centi >= TEMP_MIN && rsp_temperature_centi <= TEMP_MAX))
      else $error("temperature outside saturation limits");

   // a held result freezes the pipeline
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(j_valid_ff) && $stable(h_valid_ff))
      else $error("pipeline moved under stall");

endmodule

/* hdl/ntcbt_div.sv */
module ntcbt_div #(
   parameter int N_W = 48,
   parameter int D_W = 32,
   parameter int Q_W = 32,
   parameter int S_W = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [N_W-1:0] in_num,
   input  logic [D_W-1:0] in_den,
   input  logic [S_W-1:0] in_side,
   output logic           out_valid,
   output logic [Q_W-1:0] out_quo,
   output logic           out_sat,
   output logic [S_W-1:0] out_side
);

   // Restoring divider, one quotient bit per stage, MSB first
   logic [N_W-1:0] rem_ff  [0:Q_W-1];
   logic [N_W-1:0] den_ff  [0:Q_W];
   logic [Q_W-1:0] quo_ff  [0:Q_W];
   logic           sat_ff  [0:Q_W];
   logic [S_W-1:0] side_ff [0:Q_W];
   logic           valid_ff[0:Q_W];

   // Entry stage: quotient overflow when num >= den * 2^Q_W
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0]  <= in_num;
         den_ff[0]  <= N_W'(in_den);
         quo_ff[0]  <= '0;
         sat_ff[0]  <= (in_num >> Q_W) >= N_W'(in_den);
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= Q_W; k++) begin : g_step
      localparam int J = Q_W - k;
      logic take;

      assign take = (rem_ff[k-1] >> J) >= den_ff[k-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (en) begin
            den_ff[k]  <= den_ff[k-1];
            quo_ff[k]  <= quo_ff[k-1] | (take ? (Q_W'(1'b1) << J) : '0);
            sat_ff[k]  <= sat_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end

      // final remainder is not needed
      if (k < Q_W) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= take ? (rem_ff[k-1] - (den_ff[k-1] << J)) : rem_ff[k-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign out_quo   = quo_ff[Q_W];
   assign out_sat   = sat_ff[Q_W];
   assign out_side  = side_ff[Q_W];

endmodule

/* tb/ntc_temperature_checker.sv */
module ntc_temperature_checker
   import ntcbt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [11:0]        req_adc_sample,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [16:0] rsp_temperature_centi,
   input  logic               rsp_reading_valid,
   output int                 mismatch_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [16:0] temp;
      logic               valid;
   } reading_type;

   reading_type expected_readings[$];

   // shadow registers
   logic [19:0]        rfix_q, r0_q;
   logic [15:0]        t0_q;
   logic [13:0]        beta_q;
   logic signed [14:0] offset_q;
   logic               fahr_q;
   logic [11:0]        rmin_q, rmax_q;

   assign pending_count = expected_readings.size();

   function automatic longint log2_fixed(logic [31:0] ratio);
      int          e;
      logic [63:0] m;
      longint      frac;
      e = 31;
      frac = 0;
      while (e > 0 && ratio[e] == 1'b0) e--;
      m = ({32'd0, ratio} << 30) >> e;
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd2 << 30)) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return longint'(e - 16) * 64'sd16777216 + frac;
   endfunction

   function automatic reading_type convert_sample(logic [11:0] raw);
      reading_type r;
      logic [63:0] rf, rn, tn, bk, q, lnmag, term, tck, inv_num;
      longint      l2, inv, tmp, n;
      logic        neg;
      inv_num = 64'd100 << 40;
      rf = (rfix_q == 0) ? 1 : rfix_q;
      rn = (r0_q == 0) ? 1 : r0_q;
      tn = (t0_q == 0) ? 1 : t0_q;
      bk = (beta_q == 0) ? 1 : beta_q;
      r.temp = '0;
      r.valid = 1'b0;
      if (raw < rmin_q || raw > rmax_q || raw == 0 || raw == 12'hFFF) return r;
      q = ((rf * raw) << 16) / ((64'd4095 - raw) * rn);
      if (q == 0) q = 1;
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
      l2 = log2_fixed(q[31:0]);
      neg = l2 < 0;
      lnmag = (64'(neg ? -l2 : l2) * 64'd744261118 + (64'd1 << 29)) >> 30;
      term = (lnmag << 16) / bk;
      inv = longint'(inv_num / tn);
      inv = neg ? inv - longint'(term) : inv + longint'(term);
      if (inv <= 0) begin
         tmp = 50000;
      end else begin
         tck = (inv_num + (64'(inv) >> 1)) / 64'(inv);
         tmp = longint'(tck) - 27315 + offset_q;
         if (fahr_q) begin
            n = tmp * 9;
            tmp = ((n >= 0) ? (n + 2) / 5 : -((-n + 2) / 5)) + 3200;
         end
         if (tmp < -10000) tmp = -10000;
         if (tmp > 50000) tmp = 50000;
      end
      r.temp = tmp[16:0];
      r.valid = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type exp_r;
      if (reset) begin
         rfix_q <= RST_FIXED_RES;
         r0_q <= RST_NOMINAL_RES;
         t0_q <= RST_NOMINAL_TEMP;
         beta_q <= RST_BETA;
         offset_q <= RST_OFFSET;
         fahr_q <= 1'b0;
         rmin_q <= RST_RAW_MIN;
         rmax_q <= RST_RAW_MAX;
         mismatch_count <= 0;
         expected_readings.delete();
      end else begin
         // writes only happen while idle, so ordering versus transfers is moot
         if (csr_we) begin
            case (csr_reg_type'(csr_index))
               REG_FIXED_RES:    rfix_q <= csr_wdata;
               REG_NOMINAL_RES:  r0_q <= csr_wdata;
               REG_NOMINAL_TEMP: t0_q <= csr_wdata[15:0];
               REG_BETA:         beta_q <= csr_wdata[13:0];
               REG_OFFSET:       offset_q <= csr_wdata[14:0];
               REG_FAHRENHEIT:   fahr_q <= csr_wdata[0];
               REG_RAW_MIN:      rmin_q <= csr_wdata[11:0];
               REG_RAW_MAX:      rmax_q <= csr_wdata[11:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_readings.push_back(convert_sample(req_adc_sample));
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result transfer: temp=%0d valid=%0b",
                           rsp_temperature_centi, rsp_reading_valid);
               mismatch_count <= mismatch_count + 1;
            end else begin
               exp_r = expected_readings.pop_front();
               if (exp_r.temp !== rsp_temperature_centi ||
                   exp_r.valid !== rsp_reading_valid) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected temp=%0d valid=%0b, got temp=%0d valid=%0b",
                              exp_r.temp, exp_r.valid, rsp_temperature_centi,
                              rsp_reading_valid);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end
endmodule

/* tb/testbench.sv */
module testbench;
   import ntcbt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 164;
   localparam int MAX_CYCLES = 400000;

   logic clock = 1'b0, reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0, rsp_stall = 1'b0;
   logic [11:0] req_adc_sample = '0;
   logic req_stall, rsp_valid, rsp_reading_valid;
   logic signed [16:0] rsp_temperature_centi;
   int mismatch_count, pending_count, cycle_count = 0;
   int idle_pct = 28;
   bit hold_rsp = 1'b0;

   // directed sample lists
   logic [11:0] dir_default [13] = '{12'd0, 12'd1, 12'd12, 12'd13, 12'd14, 12'd2048,
                                     12'd4081, 12'd4082, 12'd4083, 12'd4094, 12'd4095,
                                     12'hAAA, 12'h555};
   logic [11:0] dir_extreme [5]  = '{12'd1, 12'd2, 12'd4093, 12'd4094, 12'd2000};
   logic [11:0] dir_swapped [3]  = '{12'd1, 12'd4094, 12'd100};
   logic [11:0] dir_inverted [3] = '{12'd500, 12'd2000, 12'd3500};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ntc_beta_temperature_convert_core dut (.*);
   ntc_temperature_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver stall process; long hold-off when asked
   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 99) < idle_pct);
   end

   task automatic write_reg(csr_reg_type idx, logic [19:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // offer one sample; valid stays high between back-to-back transfers
   task automatic send_sample(logic [11:0] s);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_adc_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic random_phase(int n);
      logic [11:0] s;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: s = 12'($urandom_range(0, 15));
            1: s = 12'($urandom_range(4080, 4095));
            default: s = 12'($urandom);
         endcase
         send_sample(s);
      end
   endtask

   task automatic random_config;
      write_reg(REG_FIXED_RES, ($urandom_range(0, 9) == 0) ? 20'd0 :
                               20'($urandom_range(1, 1000000)));
      write_reg(REG_NOMINAL_RES, ($urandom_range(0, 9) == 0) ? 20'hFFFFF :
                                 20'($urandom_range(1, 1000000)));
      write_reg(REG_NOMINAL_TEMP, 20'($urandom_range(20000, 40000)));
      write_reg(REG_BETA, 20'($urandom_range(1000, 10000)));
      write_reg(REG_OFFSET, 20'(15'($urandom_range(0, 20000) - 10000)));
      write_reg(REG_FAHRENHEIT, 20'($urandom_range(0, 1)));
      write_reg(REG_RAW_MIN, 20'($urandom_range(1, 200)));
      write_reg(REG_RAW_MAX, 20'($urandom_range(3900, 4094)));
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: defaults, window edges, rails, alternating bits
      foreach (dir_default[i]) send_sample(dir_default[i]);
      drain();

      // extremes: zero registers treated as one, wide window, Fahrenheit, max offset
      write_reg(REG_FIXED_RES, 20'd0);
      write_reg(REG_NOMINAL_RES, 20'hFFFFF);
      write_reg(REG_NOMINAL_TEMP, 20'hFFFF);
      write_reg(REG_BETA, 20'd0);
      write_reg(REG_OFFSET, 20'(15'sd10000));
      write_reg(REG_FAHRENHEIT, 20'd1);
      write_reg(REG_RAW_MIN, 20'd1);
      write_reg(REG_RAW_MAX, 20'd4094);
      foreach (dir_extreme[i]) send_sample(dir_extreme[i]);
      drain();
      write_reg(REG_FIXED_RES, 20'hFFFFF);
      write_reg(REG_NOMINAL_RES, 20'd0);
      write_reg(REG_NOMINAL_TEMP, 20'd0);
      write_reg(REG_BETA, 20'h3FFF);
      write_reg(REG_OFFSET, 20'(-15'sd10000));
      foreach (dir_swapped[i]) send_sample(dir_swapped[i]);
      drain();

      // inverted window: nothing valid
      write_reg(REG_RAW_MIN, 20'd3000);
      write_reg(REG_RAW_MAX, 20'd1000);
      foreach (dir_inverted[i]) send_sample(dir_inverted[i]);
      drain();

      // random phases; one without idling, one with the receiver held off
      for (int p = 0; p < 6; p++) begin
         random_config();
         if (p == 2) idle_pct = 0;
         if (p == 3) begin
            idle_pct = 28;
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (400) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         random_phase(145);
         drain();
      end

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
